// ===== hw/rtl/eba_pkg.sv =====
// Shared constants and types for the backfill admission engine.
`default_nettype none
package eba_pkg;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 40;
    localparam int NODE_W          = 11;
    localparam int ID_W            = 16;
    localparam int CMD_W           = 2;

    localparam logic [CMD_W-1:0] CMD_PRIO   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BFILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_SCANW  = 7'b0000100,
        ST_SHIFT  = 7'b0001000,
        ST_SHIFTW = 7'b0010000,
        ST_PLACE  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/eba_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module eba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/easy_backfill_admission_core.sv =====
// Top level of the EASY backfilling admission engine.
//  channel  | signals                                         | handshake
//  command  | cmd job_id job_nodes walltime now              | start & !busy
//  result   | can_run job_found table_full free_after        | done strobe
//           | shadow_out extra_out running_jobs              |
//  config   | cfg_we cfg_wdata                               | cfg_we & !busy
// Per command, the table memory is read one entry per cycle to scan (registered
// read), then entries are moved one at a time, each read in ST_SHIFTW and written
// in ST_SHIFT, for sorted insert or removal.
// Reset clears count and reservation and sets free and total counts to the node cap;
// table contents stay undefined. Results cannot be stalled; done pulses for one cycle per command.
`default_nettype none
module easy_backfill_admission_core #(
    parameter int MAX_NODES   = eba_pkg::MAX_NODES_DEF,
    parameter int TABLE_DEPTH = eba_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = eba_pkg::TIME_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [eba_pkg::CMD_W-1:0]   cmd,
    input  wire logic [eba_pkg::ID_W-1:0]    job_id,
    input  wire logic [eba_pkg::NODE_W-1:0]  job_nodes,
    input  wire logic [TIME_BITS-1:0]        walltime,
    input  wire logic [TIME_BITS-1:0]        now,
    input  wire logic                        cfg_we,
    input  wire logic [eba_pkg::NODE_W-1:0]  cfg_wdata,
    output logic                             done,
    output logic                             can_run,
    output logic                             job_found,
    output logic                             table_full,
    output logic [eba_pkg::NODE_W-1:0]       free_after,
    output logic [TIME_BITS-1:0]             shadow_out,
    output logic [eba_pkg::NODE_W-1:0]       extra_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] running_jobs
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH+1);
    localparam int NW  = eba_pkg::NODE_W;
    localparam int IW  = eba_pkg::ID_W;
    localparam int EW  = IW + NW + TIME_BITS;
    localparam int ACW = NW + CW + 1;
    localparam logic [NW-1:0] NODE_CAP =
        (MAX_NODES < 1024) ? NW'(MAX_NODES) : NW'(1024);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    typedef enum logic [1:0] {OP_INS, OP_SHADOW, OP_FIND} op_t;

    eba_pkg::state_t state_reg, state_next;
    op_t             op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   free_reg, free_next, total_reg, total_next;
    logic            pv_reg, pv_next;
    logic [IW-1:0]   pid_reg, pid_next;
    logic [NW-1:0]   pnodes_reg, pnodes_next, pextra_reg, pextra_next;
    logic [TIME_BITS-1:0] pshadow_reg, pshadow_next, pend_reg, pend_next;
    logic [CW-1:0]   idx_reg, idx_next, pos_reg, pos_next;
    logic [ACW-1:0]  acc_reg, acc_next;
    logic [IW-1:0]   id_reg, id_next;
    logic [NW-1:0]   nodes_reg, nodes_next;
    logic [TIME_BITS-1:0] fin_reg, fin_next, wall_reg, wall_next;
    logic            late_reg, late_next;
    logic            can_reg, can_next, found_reg, found_next, full_reg, full_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;
    logic [IW-1:0]   r_id;
    logic [NW-1:0]   r_nodes;
    logic [TIME_BITS-1:0] r_fin;
    logic [TIME_BITS:0] fsum;
    logic [TIME_BITS-1:0] fin_in;
    logic [TIME_BITS:0] esum;
    logic [ACW-1:0]  acc_add;
    logic [NW:0]     fsum_n;
    logic [NW-1:0]   lim;

    eba_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign {r_id, r_nodes, r_fin} = rdata;
    assign fsum    = {1'b0, now} + {1'b0, walltime};
    assign fin_in  = fsum[TIME_BITS] ? TMAX : fsum[TIME_BITS-1:0];
    assign esum    = {1'b0, r_fin} + {1'b0, wall_reg};
    assign acc_add = acc_reg + ACW'(r_nodes);
    assign fsum_n  = {1'b0, free_reg} + {1'b0, r_nodes};
    assign busy    = (state_reg != eba_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg; op_next = op_reg; cnt_next = cnt_reg;
        free_next = free_reg; total_next = total_reg; pv_next = pv_reg;
        pid_next = pid_reg; pnodes_next = pnodes_reg; pextra_next = pextra_reg;
        pshadow_next = pshadow_reg; pend_next = pend_reg; idx_next = idx_reg;
        pos_next = pos_reg; acc_next = acc_reg; id_next = id_reg;
        nodes_next = nodes_reg; fin_next = fin_reg; wall_next = wall_reg;
        late_next = late_reg; can_next = can_reg;
        found_next = found_reg; full_next = full_reg;
        we = 1'b0; waddr = idx_reg[AW-1:0]; wdata = rdata;
        raddr = idx_reg[AW-1:0]; lim = free_reg;
        unique case (state_reg)
            eba_pkg::ST_IDLE:
            begin
                if (cfg_we)
                begin
                    total_next = (cfg_wdata > NODE_CAP) ? NODE_CAP : cfg_wdata;
                    free_next  = total_next;
                end
                if (start)
                begin
                    can_next = 1'b0; found_next = 1'b0; full_next = 1'b0;
                    id_next = job_id; fin_next = fin_in; wall_next = walltime;
                    idx_next = '0; raddr = '0; acc_next = ACW'(free_reg);
                    late_next = 1'b0; state_next = eba_pkg::ST_DONE;
                    if (cmd == eba_pkg::CMD_PRIO)
                    begin
                        nodes_next = pnodes_reg;
                        if (!pv_reg || pid_reg != job_id)
                        begin
                            pv_next = 1'b1; pid_next = job_id; pnodes_next = job_nodes;
                            pshadow_next = '0; pend_next = '0; pextra_next = '0;
                            nodes_next = job_nodes;
                        end
                        acc_next = ACW'(free_reg);
                        if (nodes_next <= free_reg)
                        begin
                            if (cnt_reg >= CW'(TABLE_DEPTH)) full_next = 1'b1;
                            else begin op_next = OP_INS; state_next = eba_pkg::ST_SCANW; end
                        end
                        else if (cnt_reg != '0)
                        begin
                            op_next = OP_SHADOW; state_next = eba_pkg::ST_SCANW;
                        end
                    end
                    else if (cmd == eba_pkg::CMD_BFILL)
                    begin
                        nodes_next = job_nodes;
                        late_next = fin_in > pshadow_reg;
                        if (late_next && pextra_reg < free_reg) lim = pextra_reg;
                        if (job_nodes <= lim)
                        begin
                            if (cnt_reg >= CW'(TABLE_DEPTH)) full_next = 1'b1;
                            else begin op_next = OP_INS; state_next = eba_pkg::ST_SCANW; end
                        end
                    end
                    else if (cmd == eba_pkg::CMD_FINISH)
                    begin
                        if (cnt_reg != '0)
                        begin
                            op_next = OP_FIND; state_next = eba_pkg::ST_SCANW;
                        end
                    end
                end
            end
            eba_pkg::ST_SCANW:
            begin
                // first read issued; data arrives next cycle
                if (op_reg == OP_INS && cnt_reg == '0)
                begin
                    pos_next = '0; state_next = eba_pkg::ST_PLACE;
                end
                else state_next = eba_pkg::ST_SCAN;
            end
            eba_pkg::ST_SCAN:
            begin
                // rdata holds entry idx_reg
                raddr = AW'(idx_reg + 1'b1);
                idx_next = idx_reg + 1'b1;
                priority case (op_reg)
                    OP_INS:
                    begin
                        if (r_fin > fin_reg)
                        begin
                            pos_next = idx_reg; idx_next = cnt_reg;
                            raddr = AW'(cnt_reg - 1'b1);
                            state_next = eba_pkg::ST_SHIFTW;
                        end
                        else if (idx_reg + 1'b1 == cnt_reg)
                        begin
                            pos_next = cnt_reg; state_next = eba_pkg::ST_PLACE;
                        end
                    end
                    OP_SHADOW:
                    begin
                        acc_next = acc_add;
                        if (acc_add >= ACW'(pnodes_reg))
                        begin
                            pshadow_next = r_fin;
                            pend_next = esum[TIME_BITS] ? TMAX : esum[TIME_BITS-1:0];
                            pextra_next = NW'(acc_add - ACW'(pnodes_reg));
                            state_next = eba_pkg::ST_DONE;
                        end
                        else if (idx_reg + 1'b1 == cnt_reg) state_next = eba_pkg::ST_DONE;
                    end
                    default:
                    begin
                        if (r_id == id_reg)
                        begin
                            found_next = 1'b1;
                            free_next = (fsum_n > {1'b0, total_reg}) ? total_reg : NW'(fsum_n);
                            idx_next = idx_reg;
                            raddr = AW'(idx_reg + 1'b1);
                            if (idx_reg + 1'b1 == cnt_reg)
                            begin
                                cnt_next = cnt_reg - 1'b1; state_next = eba_pkg::ST_DONE;
                            end
                            else state_next = eba_pkg::ST_SHIFTW;
                        end
                        else if (idx_reg + 1'b1 == cnt_reg) state_next = eba_pkg::ST_DONE;
                    end
                endcase
            end
            eba_pkg::ST_SHIFTW:
            begin
                // hold the read of the entry to move
                if (op_reg == OP_INS) raddr = AW'(idx_reg - 1'b1);
                else raddr = AW'(idx_reg + 1'b1);
                state_next = eba_pkg::ST_SHIFT;
            end
            eba_pkg::ST_SHIFT:
            begin
                we = 1'b1; wdata = rdata;
                if (op_reg == OP_INS)
                begin
                    // move entry idx-1 to idx
                    waddr = idx_reg[AW-1:0];
                    idx_next = idx_reg - 1'b1;
                    raddr = AW'(idx_reg - 2'd2);
                    if (idx_reg - 1'b1 == pos_reg) state_next = eba_pkg::ST_PLACE;
                    else state_next = eba_pkg::ST_SHIFTW;
                end
                else
                begin
                    // move entry idx+1 to idx
                    waddr = idx_reg[AW-1:0];
                    idx_next = idx_reg + 1'b1;
                    raddr = AW'(idx_reg + 2'd2);
                    if (idx_reg + 2'd2 == cnt_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1; state_next = eba_pkg::ST_DONE;
                    end
                    else state_next = eba_pkg::ST_SHIFTW;
                end
            end
            eba_pkg::ST_PLACE:
            begin
                we = 1'b1; waddr = pos_reg[AW-1:0];
                wdata = {id_reg, nodes_reg, fin_reg};
                cnt_next = cnt_reg + 1'b1;
                free_next = (nodes_reg > free_reg) ? '0 : free_reg - nodes_reg;
                can_next = 1'b1;
                if (late_reg)
                    pextra_next = (nodes_reg > pextra_reg) ? '0 : pextra_reg - nodes_reg;
                state_next = eba_pkg::ST_DONE;
            end
            eba_pkg::ST_DONE:
            begin
                state_next = eba_pkg::ST_IDLE;
            end
            default: state_next = eba_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eba_pkg::ST_IDLE; cnt_reg <= '0;
            free_reg <= NODE_CAP; total_reg <= NODE_CAP; pv_reg <= 1'b0;
            pid_reg <= '0; pnodes_reg <= '0; pextra_reg <= '0;
            pshadow_reg <= '0; pend_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; cnt_reg <= cnt_next;
            free_reg <= free_next; total_reg <= total_next; pv_reg <= pv_next;
            pid_reg <= pid_next; pnodes_reg <= pnodes_next; pextra_reg <= pextra_next;
            pshadow_reg <= pshadow_next; pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; idx_reg <= idx_next; pos_reg <= pos_next;
        acc_reg <= acc_next; id_reg <= id_next; nodes_reg <= nodes_next;
        fin_reg <= fin_next; wall_reg <= wall_next; late_reg <= late_next;
        can_reg <= can_next; found_reg <= found_next; full_reg <= full_next;
    end

    assign done         = (state_reg == eba_pkg::ST_DONE);
    assign can_run      = can_reg;
    assign job_found    = found_reg;
    assign table_full   = full_reg;
    assign free_after   = free_reg;
    assign shadow_out   = pshadow_reg;
    assign extra_out    = pextra_reg;
    assign running_jobs = cnt_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH)) else $error("count over depth");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= total_reg) else $error("free over total");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(can_run && (job_found || table_full))) else $error("flags clash");
`endif
endmodule
`default_nettype wire

// ===== tb/eba_checker.sv =====
// Checker for the backfill admission engine: predicts and compares every result transfer.
`timescale 1ns / 1ps
module eba_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [eba_pkg::CMD_W-1:0]  cmd,
    input  wire logic [eba_pkg::ID_W-1:0]   job_id,
    input  wire logic [eba_pkg::NODE_W-1:0] job_nodes,
    input  wire logic [39:0]                walltime,
    input  wire logic [39:0]                now,
    input  wire logic                       cfg_we,
    input  wire logic [eba_pkg::NODE_W-1:0] cfg_wdata,
    input  wire logic                       done,
    input  wire logic                       can_run,
    input  wire logic                       job_found,
    input  wire logic                       table_full,
    input  wire logic [eba_pkg::NODE_W-1:0] free_after,
    input  wire logic [39:0]                shadow_out,
    input  wire logic [eba_pkg::NODE_W-1:0] extra_out,
    input  wire logic [6:0]                 running_jobs,
    output int                              pending,
    output int                              errors
);
    localparam int DEPTH = 64;
    localparam int NW    = eba_pkg::NODE_W;
    localparam int IW    = eba_pkg::ID_W;

    typedef struct packed {
        logic          can_run;
        logic          job_found;
        logic          table_full;
        logic [NW-1:0] free_after;
        logic [39:0]   shadow;
        logic [NW-1:0] extra;
        logic [6:0]    running;
    } verdict_t;

    verdict_t      verdict_q[$];
    logic [IW-1:0] run_id[DEPTH];
    logic [NW-1:0] run_nodes[DEPTH];
    logic [39:0]   run_fin[DEPTH];
    int            run_cnt;
    int            free_cnt;
    int            total_cnt;
    logic          res_valid;
    logic [IW-1:0] res_id;
    int            res_nodes;
    logic [39:0]   res_shadow;
    logic [39:0]   res_end;
    int            res_extra;

    assign pending = verdict_q.size();

    function automatic logic [39:0] sat_add(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? '1 : s[39:0];
    endfunction

    function automatic bit place_job(logic [IW-1:0] id, int nodes, logic [39:0] fin);
        int pos;
        if (run_cnt >= DEPTH)
            return 0;
        pos = 0;
        while (pos < run_cnt && run_fin[pos] <= fin)
            pos++;
        for (int k = run_cnt; k > pos; k--)
        begin
            run_id[k]    = run_id[k-1];
            run_nodes[k] = run_nodes[k-1];
            run_fin[k]   = run_fin[k-1];
        end
        run_id[pos]    = id;
        run_nodes[pos] = nodes[NW-1:0];
        run_fin[pos]   = fin;
        run_cnt++;
        free_cnt = (nodes > free_cnt) ? 0 : free_cnt - nodes;
        return 1;
    endfunction

    function automatic verdict_t admit_job(logic [eba_pkg::CMD_W-1:0] c, logic [IW-1:0] id,
                                           int nodes, logic [39:0] wall, logic [39:0] t);
        verdict_t    v;
        logic [39:0] fin;
        int          acc;
        int          lim;
        int          k;
        bit          late;
        v = '0;
        fin = sat_add(t, wall);
        if (c == eba_pkg::CMD_PRIO)
        begin
            if (!res_valid || res_id != id)
            begin
                res_valid  = 1;
                res_id     = id;
                res_nodes  = nodes;
                res_shadow = '0;
                res_end    = '0;
                res_extra  = 0;
            end
            if (res_nodes <= free_cnt)
            begin
                if (place_job(id, res_nodes, fin))
                    v.can_run = 1;
                else
                    v.table_full = 1;
            end
            else
            begin
                acc = free_cnt;
                for (k = 0; k < run_cnt; k++)
                begin
                    acc += int'(run_nodes[k]);
                    if (acc >= res_nodes)
                    begin
                        res_shadow = run_fin[k];
                        res_end    = sat_add(run_fin[k], wall);
                        res_extra  = (acc - res_nodes) & 32'h7FF;
                        break;
                    end
                end
            end
        end
        else if (c == eba_pkg::CMD_BFILL)
        begin
            late = fin > res_shadow;
            lim = free_cnt;
            if (late && res_extra < lim)
                lim = res_extra;
            if (nodes <= lim)
            begin
                if (place_job(id, nodes, fin))
                begin
                    v.can_run = 1;
                    if (late)
                        res_extra = (nodes > res_extra) ? 0 : res_extra - nodes;
                end
                else
                    v.table_full = 1;
            end
        end
        else if (c == eba_pkg::CMD_FINISH)
        begin
            for (k = 0; k < run_cnt; k++)
                if (run_id[k] == id)
                    break;
            if (k < run_cnt)
            begin
                v.job_found = 1;
                acc = free_cnt + int'(run_nodes[k]);
                free_cnt = (acc > total_cnt) ? total_cnt : acc;
                for (; k + 1 < run_cnt; k++)
                begin
                    run_id[k]    = run_id[k+1];
                    run_nodes[k] = run_nodes[k+1];
                    run_fin[k]   = run_fin[k+1];
                end
                run_cnt--;
            end
        end
        v.free_after = free_cnt[NW-1:0];
        v.shadow     = res_shadow;
        v.extra      = res_extra[NW-1:0];
        v.running    = run_cnt[6:0];
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            verdict_q.delete();
            errors     = 0;
            run_cnt    = 0;
            total_cnt  = 1024;
            free_cnt   = 1024;
            res_valid  = 0;
            res_id     = '0;
            res_nodes  = 0;
            res_shadow = '0;
            res_end    = '0;
            res_extra  = 0;
        end
        else
        begin
            if (done)
            begin
                got = '{can_run, job_found, table_full, free_after, shadow_out,
                        extra_out, running_jobs};
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result transfer with none expected: %p", $realtime, got);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    end
                end
            end
            if (cfg_we)
            begin
                total_cnt = (cfg_wdata > 11'd1024) ? 1024 : int'(cfg_wdata);
                free_cnt  = total_cnt;
            end
            if (start && !busy)
                verdict_q.insert(verdict_q.size(),
                                 admit_job(cmd, job_id, int'(job_nodes), walltime, now));
        end
    end
endmodule

// ===== tb/tb_easy_backfill_admission_core.sv =====
// Top of the admission engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_easy_backfill_admission_core;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN       = 160;
    localparam int CW          = eba_pkg::CMD_W;
    localparam int IW          = eba_pkg::ID_W;
    localparam int NW          = eba_pkg::NODE_W;

    logic          clk = 0;
    logic          rst_n = 0;
    logic          start = 0;
    logic          busy;
    logic [CW-1:0] cmd = '0;
    logic [IW-1:0] job_id = '0;
    logic [NW-1:0] job_nodes = '0;
    logic [39:0]   walltime = '0;
    logic [39:0]   now = '0;
    logic          cfg_we = 0;
    logic [NW-1:0] cfg_wdata = '0;
    logic          done;
    logic          can_run;
    logic          job_found;
    logic          table_full;
    logic [NW-1:0] free_after;
    logic [39:0]   shadow_out;
    logic [NW-1:0] extra_out;
    logic [6:0]    running_jobs;
    int            pending;
    int            errors;
    int            cycles = 0;
    logic [39:0]   clock_ticks = '0;
    int            cur_total = 1024;
    bit            gaps_on = 1;
    logic [IW-1:0] head_id = '0;

    always #1 clk = ~clk;

    easy_backfill_admission_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .job_id(job_id), .job_nodes(job_nodes), .walltime(walltime), .now(now),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .can_run(can_run),
        .job_found(job_found), .table_full(table_full), .free_after(free_after),
        .shadow_out(shadow_out), .extra_out(extra_out), .running_jobs(running_jobs)
    );

    eba_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .job_id(job_id), .job_nodes(job_nodes), .walltime(walltime), .now(now),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .can_run(can_run),
        .job_found(job_found), .table_full(table_full), .free_after(free_after),
        .shadow_out(shadow_out), .extra_out(extra_out), .running_jobs(running_jobs),
        .pending(pending), .errors(errors)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [39:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    task automatic send(logic [CW-1:0] c, logic [IW-1:0] id, logic [NW-1:0] n,
                        logic [39:0] wall, logic [39:0] t);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1;
        cmd       <= c;
        job_id    <= id;
        job_nodes <= n;
        walltime  <= wall;
        now       <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic settle();
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_total(logic [NW-1:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 0;
        cur_total = (v > 11'd1024) ? 1024 : ((v == '0) ? 1 : int'(v));
    endtask

    task automatic random_item(bit fill);
        int            r;
        logic [CW-1:0] c;
        logic [IW-1:0] id;
        logic [NW-1:0] n;
        logic [39:0]   wall;
        r = $urandom_range(0, 99);
        clock_ticks += 40'($urandom_range(0, 100));
        id   = IW'($urandom_range(0, 31));
        n    = fill ? NW'($urandom_range(0, 1)) : NW'($urandom_range(0, cur_total / 4 + 1));
        wall = 40'($urandom_range(1, 5000));
        if ($urandom_range(0, 9) == 0)
            n = NW'($urandom_range(0, 2047));
        if ($urandom_range(0, 19) == 0)
            wall = rand40();
        if (r < 35)
        begin
            c = eba_pkg::CMD_PRIO;
            if ($urandom_range(0, 9) < 6)
                id = head_id;
            head_id = id;
        end
        else if (r < 70)
            c = eba_pkg::CMD_BFILL;
        else if (r < (fill ? 75 : 95))
            c = eba_pkg::CMD_FINISH;
        else
            c = CW'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0)
            send(CW'($urandom_range(0, 3)), IW'($urandom), NW'($urandom), rand40(), rand40());
        else if ($urandom_range(0, 29) == 0)
            send(c, IW'($urandom), n, wall, rand40());
        else
            send(c, id, n, wall, clock_ticks);
    endtask

    initial
    begin
        logic [NW-1:0] totals[6];
        totals = '{11'd2047, 11'd1, 11'd300, 11'd64, 11'd0, 11'd1024};
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        write_total(11'd1024);

        gaps_on = 1;
        send(eba_pkg::CMD_PRIO, 16'd1, 11'd1024, 40'd100, 40'd0);
        send(eba_pkg::CMD_PRIO, 16'd2, 11'd5, 40'd50, 40'd10);
        send(eba_pkg::CMD_PRIO, 16'd2, 11'd900, 40'd50, 40'd20);
        send(eba_pkg::CMD_BFILL, 16'd3, 11'd0, 40'd10, 40'd20);
        send(eba_pkg::CMD_FINISH, 16'd1, 11'd0, 40'd0, 40'd30);
        send(eba_pkg::CMD_FINISH, 16'd1, 11'd0, 40'd0, 40'd31);
        send(eba_pkg::CMD_PRIO, 16'd4, 11'd1000, 40'd500, 40'd40);
        send(eba_pkg::CMD_PRIO, 16'hFFFF, 11'd2047, '1, '1);
        send(eba_pkg::CMD_BFILL, 16'd5, 11'd10, 40'd5, 40'd40);
        send(eba_pkg::CMD_BFILL, 16'd6, 11'd10, 40'd5000, 40'd40);
        send(eba_pkg::CMD_BFILL, 16'd7, 11'd2047, '1, 40'd1);
        send(2'd3, 16'hFFFF, 11'h7FF, '1, '1);
        send(eba_pkg::CMD_FINISH, 16'd3, 11'h7FF, '1, '0);
        send(eba_pkg::CMD_PRIO, 16'd0, 11'd0, '1, 40'hFF_FFFF_FF00);
        send(eba_pkg::CMD_FINISH, 16'hFFFF, 11'd0, 40'd0, 40'd0);
        send(eba_pkg::CMD_FINISH, 16'd0, 11'd0, 40'd0, 40'd0);
        clock_ticks = 40'd100;

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_total(totals[p]);
            for (int i = 0; i < 125; i++)
            begin
                if (i % 40 == 0)
                    gaps_on = $urandom_range(0, 2) != 0;
                random_item(p == 3 || p == 4);
            end
        end

        settle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/eba_pkg.sv
hw/rtl/eba_ram.sv
hw/rtl/easy_backfill_admission_core.sv
tb/eba_checker.sv
tb/tb_easy_backfill_admission_core.sv
